[design/mer_pkg.sv]
// Shared types and constants of the midpoint ellipse rasterizer.
package mer_pkg;

    localparam int PIX_W       = 14;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int RESTART_BIT = 0;

    localparam logic [1:0] PIX_LAST = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS_X = 2'd0,
        CFG_RADIUS_Y = 2'd1,
        CFG_CENTRE_X = 2'd2,
        CFG_CENTRE_Y = 2'd3
    } cfg_reg_t;

    // operations of the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RESTART,
        MUL_UX_SQ,
        MUL_RY2_UX,
        MUL_T_SQ,
        MUL_RX2_T,
        MUL_RX2_RY2
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHECK,
        ST_ENT_UX,
        ST_ENT_RY2,
        ST_ENT_T,
        ST_ENT_RX2T,
        ST_ENT_FIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        mul_op_t    mul_op;
        logic       end_walk;
        logic       pix_load;
        logic [1:0] pix_sel;
        logic       upd;
    } ctl_cmd_t;

    typedef struct packed {
        logic walk_active;
        logic in_region_two;
        logic x_ge_y;
        logic y_neg;
        logic out_free;
    } ctl_status_t;

endpackage

[design/mer_ctrl.sv]
// Sequencing controller of the midpoint ellipse rasterizer.
module mer_ctrl
    import mer_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  ctl_status_t           status,
    output ctl_cmd_t              cmd
);

    state_t     state_reg, state_next;
    logic [1:0] pix_cnt_reg, pix_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pix_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            pix_cnt_reg <= pix_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        pix_cnt_next = pix_cnt_reg;
        s_tready     = 1'b0;
        cmd          = '{mul_op: MUL_NONE, end_walk: 1'b0, pix_load: 1'b0,
                         pix_sel: pix_cnt_reg, upd: 1'b0};
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = s_tdata[RESTART_BIT] ? ST_INIT : ST_CHECK;
                end
            end
            ST_INIT: begin
                cmd.mul_op = MUL_RESTART;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!status.walk_active) begin
                    state_next = ST_IDLE;
                end else if (!status.in_region_two && status.x_ge_y) begin
                    state_next = ST_ENT_UX;
                end else if (status.in_region_two && status.y_neg) begin
                    cmd.end_walk = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    pix_cnt_next = '0;
                    state_next   = ST_EMIT;
                end
            end
            // region two decision rebuilt over five multiplier passes
            ST_ENT_UX: begin
                cmd.mul_op = MUL_UX_SQ;
                state_next = ST_ENT_RY2;
            end
            ST_ENT_RY2: begin
                cmd.mul_op = MUL_RY2_UX;
                state_next = ST_ENT_T;
            end
            ST_ENT_T: begin
                cmd.mul_op = MUL_T_SQ;
                state_next = ST_ENT_RX2T;
            end
            ST_ENT_RX2T: begin
                cmd.mul_op = MUL_RX2_T;
                state_next = ST_ENT_FIN;
            end
            ST_ENT_FIN: begin
                cmd.mul_op = MUL_RX2_RY2;
                state_next = ST_CHECK;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.pix_load = 1'b1;
                    pix_cnt_next = pix_cnt_reg + 2'd1;
                    if (pix_cnt_reg == PIX_LAST) begin
                        cmd.upd    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/mer_datapath.sv]
// Datapath of the midpoint ellipse rasterizer: config, walk state, multiplier, pixel register.
module mer_datapath
    import mer_pkg::*;
#(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  ctl_cmd_t               cmd,
    output ctl_status_t            status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    localparam int R2 = 2 * RADIUS_BITS;          // squared radius
    localparam int XW = RADIUS_BITS + 1;          // cur_x
    localparam int YW = RADIUS_BITS + 2;          // cur_y, signed
    localparam int SW = 3 * RADIUS_BITS + 3;      // dx, dy
    localparam int MW = 2 * RADIUS_BITS + 4;      // multiplier operand
    localparam int DW = 2 * MW;                   // decision, product
    localparam int EW = COORD_BITS + RADIUS_BITS + 2;

    // configuration; the horizontal radius is only ever needed squared
    logic [RADIUS_BITS-1:0] radius_y_reg;
    logic [COORD_BITS-1:0]  centre_x_reg, centre_y_reg;
    logic [R2-1:0]          rx2_reg, ry2_reg;
    logic [R2-1:0]          sq_in;

    assign sq_in = R2'(cfg_data[RADIUS_BITS-1:0]) * R2'(cfg_data[RADIUS_BITS-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_y_reg <= '0;
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            rx2_reg      <= '0;
            ry2_reg      <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_RADIUS_X: begin
                    rx2_reg      <= sq_in;
                end
                CFG_RADIUS_Y: begin
                    radius_y_reg <= cfg_data[RADIUS_BITS-1:0];
                    ry2_reg      <= sq_in;
                end
                CFG_CENTRE_X: centre_x_reg <= cfg_data[COORD_BITS-1:0];
                CFG_CENTRE_Y: centre_y_reg <= cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // walk state
    logic [XW-1:0]        cur_x_reg, cur_x_next;
    logic signed [YW-1:0] cur_y_reg, cur_y_next;
    logic signed [SW-1:0] sx_reg, sx_next;
    logic signed [SW-1:0] sy_reg, sy_next;
    logic [DW-1:0]        decision_reg, decision_next;
    logic [DW-1:0]        acc_reg, acc_next;
    logic [MW-1:0]        prod_reg, prod_next;
    logic                 in_region_two_reg, in_region_two_next;
    logic                 walk_active_reg, walk_active_next;

    // shared multiplier
    logic [MW-1:0]        mul_a, mul_b, ux_op, t_mag;
    logic [DW-1:0]        mul_res;
    logic signed [YW:0]   t_val;
    logic [YW-1:0]        t_abs;

    assign ux_op = MW'({cur_x_reg, 1'b1});
    assign t_val = (YW+1)'(cur_y_reg) - 1'b1;
    assign t_abs = t_val[YW] ? YW'(~t_val + 1'b1) : YW'(t_val);
    assign t_mag = MW'(t_abs);

    always_comb begin
        mul_a = MW'(rx2_reg);
        mul_b = MW'(ry2_reg);
        case (cmd.mul_op)
            MUL_RESTART: mul_b = MW'(radius_y_reg);
            MUL_UX_SQ: begin
                mul_a = ux_op;
                mul_b = ux_op;
            end
            MUL_RY2_UX: begin
                mul_a = MW'(ry2_reg);
                mul_b = prod_reg;
            end
            MUL_T_SQ: begin
                mul_a = t_mag;
                mul_b = t_mag;
            end
            MUL_RX2_T: mul_b = prod_reg;
            default: ;
        endcase
    end

    assign mul_res = DW'(mul_a) * DW'(mul_b);

    // step update terms
    logic [DW-1:0] sx_e, sy_e, rx2_e, ry2_e, sx_inc, sy_dec;
    logic          dec_neg, dec_pos, done;

    assign sx_e    = DW'(sx_reg);
    assign sy_e    = DW'(sy_reg);
    assign rx2_e   = DW'(rx2_reg);
    assign ry2_e   = DW'(ry2_reg);
    assign sx_inc  = sx_e + (ry2_e << 1);
    assign sy_dec  = sy_e - (rx2_e << 1);
    assign dec_neg = decision_reg[DW-1];
    assign dec_pos = !dec_neg && (|decision_reg);
    assign done    = in_region_two_reg && (cur_y_reg == '0);

    always_comb begin
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        sx_next            = sx_reg;
        sy_next            = sy_reg;
        decision_next      = decision_reg;
        acc_next           = acc_reg;
        prod_next          = prod_reg;
        in_region_two_next = in_region_two_reg;
        walk_active_next   = walk_active_reg;

        case (cmd.mul_op)
            MUL_RESTART: begin
                cur_x_next         = '0;
                cur_y_next         = YW'(radius_y_reg);
                sx_next            = '0;
                sy_next            = SW'(mul_res << 1);
                decision_next      = (ry2_e << 2) - (mul_res << 2) + rx2_e;
                in_region_two_next = 1'b0;
                walk_active_next   = 1'b1;
            end
            MUL_UX_SQ:  prod_next = mul_res[MW-1:0];
            MUL_RY2_UX: acc_next  = mul_res;
            MUL_T_SQ:   prod_next = mul_res[MW-1:0];
            MUL_RX2_T:  acc_next  = acc_reg + (mul_res << 2);
            MUL_RX2_RY2: begin
                decision_next      = acc_reg - (mul_res << 2);
                in_region_two_next = 1'b1;
            end
            default: ;
        endcase

        if (cmd.end_walk) begin
            walk_active_next = 1'b0;
        end

        if (cmd.upd) begin
            if (!in_region_two_reg) begin
                cur_x_next = cur_x_reg + 1'b1;
                sx_next    = sx_inc[SW-1:0];
                if (dec_neg) begin
                    decision_next = decision_reg + ((sx_inc + ry2_e) << 2);
                end else begin
                    cur_y_next    = cur_y_reg - 1'b1;
                    sy_next       = sy_dec[SW-1:0];
                    decision_next = decision_reg + ((sx_inc - sy_dec + ry2_e) << 2);
                end
            end else begin
                cur_y_next = cur_y_reg - 1'b1;
                sy_next    = sy_dec[SW-1:0];
                if (dec_pos) begin
                    decision_next = decision_reg + ((rx2_e - sy_dec) << 2);
                end else begin
                    cur_x_next    = cur_x_reg + 1'b1;
                    sx_next       = sx_inc[SW-1:0];
                    decision_next = decision_reg + ((sx_inc - sy_dec + rx2_e) << 2);
                end
                if (done) begin
                    walk_active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_region_two_reg <= 1'b0;
            walk_active_reg   <= 1'b0;
        end else begin
            in_region_two_reg <= in_region_two_next;
            walk_active_reg   <= walk_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        decision_reg <= decision_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
    end

    // pixel output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [PIX_W-1:0]   pix_x_reg, pix_y_reg;
    logic               last_reg, done_reg;
    logic [EW-1:0]      x_w, y_w, cx_w, cy_w, px_w, py_w;
    logic               out_free;

    assign x_w  = EW'(cur_x_reg);
    assign y_w  = EW'(cur_y_reg);
    assign cx_w = EW'(centre_x_reg);
    assign cy_w = EW'(centre_y_reg);
    assign px_w = cmd.pix_sel[0] ? (cx_w - x_w) : (cx_w + x_w);
    assign py_w = cmd.pix_sel[1] ? (cy_w - y_w) : (cy_w + y_w);

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.pix_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_load) begin
            pix_x_reg <= px_w[PIX_W-1:0];
            pix_y_reg <= py_w[PIX_W-1:0];
            last_reg  <= (cmd.pix_sel == PIX_LAST);
            done_reg  <= done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2 * PIX_W){1'b0}}, pix_y_reg, pix_x_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

    // dx >= dy test for leaving region one
    logic signed [SW:0] dxy;

    assign dxy = {sx_reg[SW-1], sx_reg} - {sy_reg[SW-1], sy_reg};

    assign status = '{walk_active:   walk_active_reg,
                      in_region_two: in_region_two_reg,
                      x_ge_y:        !dxy[SW],
                      y_neg:         cur_y_reg[YW-1],
                      out_free:      out_free};

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pix_load |-> out_free)
        else $error("pixel loaded over an untaken beat");

    a_walk_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.upd && in_region_two_reg && cur_y_reg == '0) |=> !walk_active_reg)
        else $error("walk still active after its final point");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mul_op == MUL_RESTART) |=> (walk_active_reg && !in_region_two_reg))
        else $error("restart did not open a region one walk");

    a_enter_r2: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mul_op == MUL_RX2_RY2) |=> in_region_two_reg)
        else $error("region two not entered after decision rebuild");
`endif

endmodule

[design/midpoint_ellipse_rasterizer_unit.sv]
// Flow: an accepted request passes an optional restart step and the region check; if the walk
// goes on, the emit state loads four pixel beats, each as the output register frees up.
// New requests wait until the last beat is loaded; leaving region one adds the decision rebuild.
// The controller sequences one shared multiplier and one pixel register.
// Reset: synchronous, active low; clears config to zero, no walk in progress, output empty.
// Top level of the midpoint ellipse rasterizer.
module midpoint_ellipse_rasterizer_unit
    import mer_pkg::*;
#(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] restart, rest zero
    // pixel channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [13:0] pixel_x, [27:14] pixel_y, rest zero
    output logic                   m_tlast,   // last_of_four
    output logic                   m_tuser,   // [0] walk_done
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    // controller: accept, region check, decision rebuild, four-beat emit
    mer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: radii squares taken on write, walk state, multiplier, output beat
    mer_datapath #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
